// File: sv/atapk_pkg.sv
package atapk_pkg;

	// packet length default, handed to the top level parameter
	localparam int PKT_LEN_DEFAULT = 12;

	// reset value of the command delay
	localparam logic [15:0] DELAY_RESET = 16'd4096;

	// item operations
	localparam logic [2:0] OP_READ8   = 3'd0;
	localparam logic [2:0] OP_READ16  = 3'd1;
	localparam logic [2:0] OP_WRITE8  = 3'd2;
	localparam logic [2:0] OP_WRITE16 = 3'd3;
	localparam logic [2:0] OP_TICK    = 3'd4;

	// register selects
	localparam logic [2:0] REG_ALT      = 3'd0;
	localparam logic [2:0] REG_DATA     = 3'd1;
	localparam logic [2:0] REG_FEATURES = 3'd2;
	localparam logic [2:0] REG_SECTCNT  = 3'd3;
	localparam logic [2:0] REG_SECTNUM  = 3'd4;
	localparam logic [2:0] REG_BCLO     = 3'd5;
	localparam logic [2:0] REG_BCHI     = 3'd6;
	localparam logic [2:0] REG_STATUS   = 3'd7;

	// error codes
	localparam logic [1:0] ERR_NONE        = 2'd0;
	localparam logic [1:0] ERR_UNMAPPED    = 2'd1;
	localparam logic [1:0] ERR_UNKNOWN_CMD = 2'd2;
	localparam logic [1:0] ERR_OVERRUN     = 2'd3;

	// command codes
	localparam logic [7:0] CMD_PACKET       = 8'hA0;
	localparam logic [7:0] CMD_SET_FEATURES = 8'hEF;
	localparam logic [7:0] PKT_TEST_UNIT    = 8'h00;
	localparam logic [7:0] PKT_REQ_MODE     = 8'h11;

	// sense key zero, disc format eight in the high nibble
	localparam logic [7:0] SENSE_READY = 8'h80;

	// packet byte holding the requested length
	localparam int REQ_LEN_BYTE = 4;

	// status bit positions
	localparam int ST_BUSY  = 7;
	localparam int ST_READY = 6;
	localparam int ST_DRQ   = 3;

	typedef enum logic [1:0] {
		PEND_NONE   = 2'd0,
		PEND_ATA    = 2'd1,
		PEND_PACKET = 2'd2
	} pend_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [2:0]  reg_sel;
		logic [15:0] write_data;
	} in_item_t;

	typedef struct packed {
		logic [15:0] read_data;
		logic        irq;
		logic [1:0]  error;
	} out_item_t;

endpackage

// File: sv/atapk_in_stage.sv
module atapk_in_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  atapk_pkg::in_item_t in_data,
	input  logic               advance,
	output logic               s1_valid,
	output atapk_pkg::in_item_t s1_item
);
	import atapk_pkg::*;

	logic     valid_s1;
	in_item_t item_s1;

	// stage is free when empty or draining this cycle
	assign in_ready = !valid_s1 || advance;

	// occupancy of the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// input beat payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	assign s1_valid = valid_s1;
	assign s1_item  = item_s1;

endmodule

// File: sv/atapk_out_stage.sv
module atapk_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  atapk_pkg::out_item_t result,
	output logic                space,
	output logic                out_valid,
	input  logic                out_ready,
	output atapk_pkg::out_item_t out_data
);
	import atapk_pkg::*;

	logic      valid_q;
	out_item_t data_q;

	// a new result may enter when empty or when the held beat leaves now
	assign space = !valid_q || out_ready;

	// occupancy of the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (space) begin
			valid_q <= load;
		end
	end

	// result beat payload
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= result;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

// File: sv/atapk_core.sv
module atapk_core #(
	parameter int PACKET_LENGTH = atapk_pkg::PKT_LEN_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  atapk_pkg::in_item_t  item,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_wdata,
	output atapk_pkg::out_item_t result
);
	import atapk_pkg::*;

	localparam int FILL_W = $clog2(PACKET_LENGTH + 1);
	localparam int IDX_W  = $clog2(PACKET_LENGTH);
	localparam logic [FILL_W-1:0] PKT_LEN_F = FILL_W'(PACKET_LENGTH);
	localparam logic [FILL_W-1:0] FILL_ONE  = FILL_W'(1);

	// drive state
	logic [15:0]       delay_q;
	logic [7:0]        pkt_q [PACKET_LENGTH];
	logic [FILL_W-1:0] fill_q, fill_d;
	logic [7:0]        status_q, status_d;
	logic [7:0]        sense_q, sense_d;
	logic [15:0]       tc_q, tc_d;
	logic [7:0]        len_q, len_d;
	logic [7:0]        pos_q, pos_d;
	pend_t             kind_q, kind_d;
	logic [7:0]        code_q, code_d;
	logic [15:0]       ticks_q, ticks_d;
	logic              irq_q, irq_d;

	// packet byte writes
	logic             we0, we1;
	logic [IDX_W-1:0] idx0, idx1;
	logic [7:0]       wb, wb_hi;
	logic [FILL_W-1:0] fill_inc;
	logic [7:0]       pos_inc, pos_inc2;
	logic [15:0]      rd;
	logic [1:0]       err;

	assign wb       = item.write_data[7:0];
	assign wb_hi    = item.write_data[15:8];
	assign fill_inc = fill_q + FILL_ONE;
	assign pos_inc  = pos_q + 8'd1;
	assign pos_inc2 = pos_q + 8'd2;
	assign idx0     = fill_q[IDX_W-1:0];
	assign idx1     = fill_inc[IDX_W-1:0];

	// next state and result for one item
	always_comb begin
		rd       = 16'h0000;
		err      = ERR_NONE;
		fill_d   = fill_q;
		status_d = status_q;
		sense_d  = sense_q;
		tc_d     = tc_q;
		len_d    = len_q;
		pos_d    = pos_q;
		kind_d   = kind_q;
		code_d   = code_q;
		ticks_d  = ticks_q;
		irq_d    = irq_q;
		we0      = 1'b0;
		we1      = 1'b0;
		case (item.op)
			OP_READ8: begin
				case (item.reg_sel)
					REG_ALT:     rd = {8'h00, status_q};
					REG_SECTNUM: rd = {8'h00, sense_q};
					REG_BCLO:    rd = {8'h00, tc_q[7:0]};
					REG_BCHI:    rd = {8'h00, tc_q[15:8]};
					REG_STATUS: begin
						rd    = {8'h00, status_q};
						irq_d = 1'b0;
					end
					default:     err = ERR_UNMAPPED;
				endcase
			end
			OP_READ16: begin
				if (item.reg_sel != REG_DATA) begin
					err = ERR_UNMAPPED;
				end else if (pos_q >= len_q) begin
					err = ERR_OVERRUN;
				end else begin
					// one halfword of zeros, stopping at the block end
					pos_d = (pos_inc < len_q) ? pos_inc2 : pos_inc;
					if (pos_d == len_q) begin
						status_d[ST_BUSY]  = 1'b0;
						status_d[ST_DRQ]   = 1'b0;
						status_d[ST_READY] = 1'b1;
						irq_d              = 1'b1;
					end
				end
			end
			OP_WRITE8: begin
				case (item.reg_sel)
					REG_ALT: ;      // device control: interrupt not masked
					REG_FEATURES: ;
					REG_SECTCNT: ;
					REG_BCLO:    tc_d[7:0]  = wb;
					REG_BCHI:    tc_d[15:8] = wb;
					REG_STATUS: begin
						kind_d            = PEND_ATA;
						code_d            = wb;
						ticks_d           = delay_q;
						status_d[ST_BUSY] = 1'b1;
					end
					default:     err = ERR_UNMAPPED;
				endcase
			end
			OP_WRITE16: begin
				if (item.reg_sel != REG_DATA) begin
					err = ERR_UNMAPPED;
				end else if (fill_q >= PKT_LEN_F) begin
					err = ERR_OVERRUN;
				end else begin
					we0 = 1'b1;
					if (fill_inc < PKT_LEN_F) begin
						we1    = 1'b1;
						fill_d = fill_inc + FILL_ONE;
					end else begin
						fill_d = fill_inc;
					end
					// full packet arms the slot with its opcode byte
					if (fill_d >= PKT_LEN_F) begin
						kind_d            = PEND_PACKET;
						code_d            = pkt_q[0];
						ticks_d           = delay_q;
						status_d[ST_BUSY] = 1'b1;
						status_d[ST_DRQ]  = 1'b0;
					end
				end
			end
			OP_TICK: begin
				if (kind_q != PEND_NONE) begin
					if (ticks_q > 16'd1) begin
						ticks_d = ticks_q - 16'd1;
					end else begin
						ticks_d           = 16'd0;
						kind_d            = PEND_NONE;
						status_d[ST_BUSY] = 1'b0;
						case (kind_q)
							PEND_ATA: begin
								if (code_q == CMD_PACKET) begin
									fill_d           = '0;
									status_d[ST_DRQ] = 1'b1;
								end else if (code_q == CMD_SET_FEATURES) begin
									irq_d = 1'b1;
								end else begin
									err = ERR_UNKNOWN_CMD;
								end
							end
							default: begin
								if (code_q == PKT_TEST_UNIT) begin
									sense_d            = SENSE_READY;
									status_d[ST_DRQ]   = 1'b0;
									status_d[ST_READY] = 1'b1;
									irq_d              = 1'b1;
								end else if (code_q == PKT_REQ_MODE) begin
									len_d            = pkt_q[REQ_LEN_BYTE];
									pos_d            = 8'd0;
									tc_d             = {8'h00, pkt_q[REQ_LEN_BYTE]};
									status_d[ST_DRQ] = 1'b1;
									irq_d            = 1'b1;
								end else begin
									err = ERR_UNKNOWN_CMD;
								end
							end
						endcase
					end
				end
			end
			default: err = ERR_UNMAPPED;
		endcase
	end

	assign result.read_data = rd;
	assign result.irq       = irq_d;
	assign result.error     = err;

	// command delay register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= DELAY_RESET;
		end else if (cfg_we) begin
			delay_q <= cfg_wdata;
		end
	end

	// control state, updated once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			status_q <= 8'h00;
			sense_q  <= 8'h00;
			tc_q     <= 16'h0000;
			len_q    <= 8'h00;
			pos_q    <= 8'h00;
			kind_q   <= PEND_NONE;
			code_q   <= 8'h00;
			ticks_q  <= 16'h0000;
			irq_q    <= 1'b0;
		end else if (advance) begin
			fill_q   <= fill_d;
			status_q <= status_d;
			sense_q  <= sense_d;
			tc_q     <= tc_d;
			len_q    <= len_d;
			pos_q    <= pos_d;
			kind_q   <= kind_d;
			code_q   <= code_d;
			ticks_q  <= ticks_d;
			irq_q    <= irq_d;
		end
	end

	// packet bytes, no reset
	always_ff @(posedge clk) begin
		if (advance && we0) begin
			pkt_q[idx0] <= wb;
		end
		if (advance && we1) begin
			pkt_q[idx1] <= wb_hi;
		end
	end

	// fill never passes the packet length
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= PKT_LEN_F)
		else $error("packet fill beyond packet length");

	// data reads never step past the block end
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= len_q)
		else $error("read position beyond block length");

	// status read drops the interrupt
	a_status_clears_irq: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item.op == OP_READ8 && item.reg_sel == REG_STATUS |=> !irq_q)
		else $error("interrupt still set after status read");

	// an overrun write leaves the packet fill alone
	a_overrun_holds: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item.op == OP_WRITE16 && item.reg_sel == REG_DATA &&
		fill_q == PKT_LEN_F |=> $stable(fill_q))
		else $error("packet fill moved on overrun");

endmodule

// File: sv/ata_packet_drive_registers.sv
// channel | direction | handshake          | beat
// in      | input     | in_valid/in_ready   | in_data: op, reg_sel, write_data
// out     | output    | out_valid/out_ready | out_data: read_data, irq, error
// cfg     | input     | cfg_we              | cfg_wdata: command delay
//
// one beat per cycle sustained while the result side is ready; each beat is held in the input
// register and moves on to the result register once that register has space
// a single logic pass lies between those two registers
// arst_n clears all control state and sets the command delay to 4096
// a stalled result register holds the input register, which then drops ready
module ata_packet_drive_registers #(
	parameter int PACKET_LENGTH = atapk_pkg::PKT_LEN_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  atapk_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output atapk_pkg::out_item_t out_data,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_wdata
);
	import atapk_pkg::*;

	logic      s1_valid;
	in_item_t  s1_item;
	logic      space;
	logic      advance;
	out_item_t result;

	// an item moves on when the result register can take it
	assign advance = s1_valid && space;

	atapk_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.advance  (advance),
		.s1_valid (s1_valid),
		.s1_item  (s1_item)
	);

	atapk_core #(
		.PACKET_LENGTH (PACKET_LENGTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.item      (s1_item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.result    (result)
	);

	atapk_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.result    (result),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// File: bench/atapk_regs_checker.sv
`timescale 1ns / 1ps

module atapk_regs_checker #(
	parameter int PKT_LEN = atapk_pkg::PKT_LEN_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  atapk_pkg::in_item_t  in_data,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  atapk_pkg::out_item_t out_data,
	input  logic                 cfg_we,
	input  logic [15:0]          cfg_wdata,
	output int                   awaiting,
	output int                   fail_count
);
	import atapk_pkg::*;

	// own copy of the drive registers
	logic [15:0] delay_q;
	logic [7:0]  pkt_mem [PKT_LEN];
	int          fill_q;
	logic [7:0]  status_q;
	logic [7:0]  sense_q;
	logic [15:0] xfer_q;
	logic [7:0]  len_q;
	logic [7:0]  pos_q;
	pend_t       kind_q;
	logic [7:0]  code_q;
	logic [15:0] ticks_q;
	logic        irq_q;

	// results still owed by the block, oldest first
	out_item_t reply_q [$];

	function automatic void clear_regs();
		delay_q  = DELAY_RESET;
		fill_q   = 0;
		status_q = '0;
		sense_q  = '0;
		xfer_q   = '0;
		len_q    = '0;
		pos_q    = '0;
		kind_q   = PEND_NONE;
		code_q   = '0;
		ticks_q  = '0;
		irq_q    = 1'b0;
		reply_q.delete();
	endfunction

	// load the single pending slot, replacing whatever was there
	function automatic void arm_slot(pend_t k, logic [7:0] c);
		kind_q = k;
		code_q = c;
		ticks_q = delay_q;
		status_q[ST_BUSY] = 1'b1;
	endfunction

	function automatic void finish_ready();
		status_q[ST_BUSY] = 1'b0;
		status_q[ST_DRQ] = 1'b0;
		status_q[ST_READY] = 1'b1;
		irq_q = 1'b1;
	endfunction

	function automatic void put_byte(logic [7:0] b);
		if (fill_q < PKT_LEN) begin
			pkt_mem[fill_q] = b;
			fill_q++;
		end
	endfunction

	// count down the slot and run the command once the delay is spent
	function automatic logic [1:0] run_tick();
		pend_t k;
		if (kind_q == PEND_NONE)
			return ERR_NONE;
		if (ticks_q > 16'd1) begin
			ticks_q = ticks_q - 16'd1;
			return ERR_NONE;
		end
		ticks_q = '0;
		k = kind_q;
		kind_q = PEND_NONE;
		status_q[ST_BUSY] = 1'b0;
		if (k == PEND_ATA) begin
			if (code_q == CMD_PACKET) begin
				fill_q = 0;
				status_q[ST_DRQ] = 1'b1;
				return ERR_NONE;
			end
			if (code_q == CMD_SET_FEATURES) begin
				irq_q = 1'b1;
				return ERR_NONE;
			end
			return ERR_UNKNOWN_CMD;
		end
		if (code_q == PKT_TEST_UNIT) begin
			sense_q = SENSE_READY;
			finish_ready();
			return ERR_NONE;
		end
		if (code_q == PKT_REQ_MODE) begin
			len_q = pkt_mem[REQ_LEN_BYTE];
			pos_q = '0;
			status_q[ST_DRQ] = 1'b1;
			xfer_q = {8'h00, len_q};
			irq_q = 1'b1;
			return ERR_NONE;
		end
		return ERR_UNKNOWN_CMD;
	endfunction

	// one bus access or tick, giving the result it must produce
	function automatic out_item_t regs_step(in_item_t it);
		out_item_t r;
		logic [7:0] wb;
		r = '0;
		wb = it.write_data[7:0];
		case (it.op)
		OP_READ8: begin
			case (it.reg_sel)
			REG_ALT:     r.read_data = {8'h00, status_q};
			REG_SECTNUM: r.read_data = {8'h00, sense_q};
			REG_BCLO:    r.read_data = {8'h00, xfer_q[7:0]};
			REG_BCHI:    r.read_data = {8'h00, xfer_q[15:8]};
			REG_STATUS: begin
				r.read_data = {8'h00, status_q};
				irq_q = 1'b0;
			end
			default:     r.error = ERR_UNMAPPED;
			endcase
		end
		OP_READ16: begin
			// data block is all zeros, reads step two bytes, or one at an odd block end
			if (it.reg_sel != REG_DATA) begin
				r.error = ERR_UNMAPPED;
			end else if (pos_q >= len_q) begin
				r.error = ERR_OVERRUN;
			end else begin
				pos_q = pos_q + 8'd1;
				if (pos_q < len_q)
					pos_q = pos_q + 8'd1;
				if (pos_q == len_q)
					finish_ready();
			end
		end
		OP_WRITE8: begin
			case (it.reg_sel)
			REG_ALT, REG_FEATURES, REG_SECTCNT: ;
			REG_BCLO:   xfer_q[7:0] = wb;
			REG_BCHI:   xfer_q[15:8] = wb;
			REG_STATUS: arm_slot(PEND_ATA, wb);
			default:    r.error = ERR_UNMAPPED;
			endcase
		end
		OP_WRITE16: begin
			if (it.reg_sel != REG_DATA) begin
				r.error = ERR_UNMAPPED;
			end else if (fill_q >= PKT_LEN) begin
				r.error = ERR_OVERRUN;
			end else begin
				put_byte(wb);
				put_byte(it.write_data[15:8]);
				if (fill_q >= PKT_LEN) begin
					arm_slot(PEND_PACKET, pkt_mem[0]);
					status_q[ST_DRQ] = 1'b0;
				end
			end
		end
		OP_TICK: r.error = run_tick();
		default: r.error = ERR_UNMAPPED;
		endcase
		r.irq = irq_q;
		return r;
	endfunction

	// results are compared before the beat of the same edge is predicted
	always @(posedge clk) begin
		out_item_t want;
		if (!arst_n) begin
			clear_regs();
			fail_count = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (reply_q.size() == 0) begin
					$display("%0t: unexpected result read_data %h irq %b error %0d",
						$time, out_data.read_data, out_data.irq, out_data.error);
					fail_count++;
				end else begin
					want = reply_q.pop_front();
					if (out_data.read_data !== want.read_data || out_data.irq !== want.irq ||
							out_data.error !== want.error) begin
						$display("%0t: expected read_data %h irq %b error %0d, got %h %b %0d",
							$time, want.read_data, want.irq, want.error,
							out_data.read_data, out_data.irq, out_data.error);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready)
				reply_q.insert(reply_q.size(), regs_step(in_data));
			if (cfg_we)
				delay_q = cfg_wdata;
		end
		awaiting = reply_q.size();
	end

endmodule

// File: bench/tb_ata_packet_drive_registers.sv
`timescale 1ns / 1ps

module tb_ata_packet_drive_registers;
	import atapk_pkg::*;

	typedef enum int {RX_FREE, RX_RANDOM, RX_PATTERN, RX_SPARSE} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_item_t   out_data;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	int          awaiting;
	int          fail_count;

	logic [15:0] cur_delay = DELAY_RESET;
	int          beats_sent = 0;
	int          burst_left = 0;
	rx_mode_t    rx_mode = RX_FREE;
	int          rx_left = 0;
	int          rx_phase = 0;

	// command delays visited after the directed part, both extremes included
	logic [15:0] delay_plan [8] = '{16'd0, 16'd1, 16'd3, 16'd65535,
		16'd2, 16'd40, 16'd0, 16'd5};

	ata_packet_drive_registers #(
		.PACKET_LENGTH(PKT_LEN_DEFAULT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	atapk_regs_checker #(
		.PKT_LEN(PKT_LEN_DEFAULT)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.awaiting(awaiting),
		.fail_count(fail_count)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// result side stalls in stretches of its own pattern
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(16, 160);
		end else begin
			rx_left--;
		end
		rx_phase++;
		case (rx_mode)
		RX_FREE:    out_ready <= 1'b1;
		RX_RANDOM:  out_ready <= ($urandom_range(0, 99) < 60);
		RX_PATTERN: out_ready <= (rx_phase % 4 != 3);
		default:    out_ready <= (rx_phase % 8 == 0);
		endcase
	end

	// offer one beat and hold it until taken, then maybe open a gap
	task automatic push_beat(input logic [2:0] op, input logic [2:0] rs,
			input logic [15:0] wd);
		in_item_t beat;
		beat.op = op;
		beat.reg_sel = rs;
		beat.write_data = wd;
		in_data <= beat;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		beats_sent++;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
				: $urandom_range(1, 12);
		end else begin
			burst_left--;
		end
	endtask

	// drop valid and wait for every owed result
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaiting != 0)
			@(posedge clk);
	endtask

	task automatic set_delay(input logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_delay = v;
	endtask

	// ticks for a command to come due, sometimes one short or one over; zero to eight for delays above 64
	task automatic cmd_ticks();
		int n;
		n = (cur_delay == 16'd0) ? 1 : int'(cur_delay);
		if (n > 64)
			n = $urandom_range(0, 8);
		else if ($urandom_range(0, 7) == 0)
			n = n - 1;
		else
			n = n + $urandom_range(0, 1);
		repeat (n) push_beat(OP_TICK, 3'($urandom), 16'($urandom));
	endtask

	initial begin
		int pick;
		int len;
		int n;
		logic [7:0] code;
		logic [7:0] pkt [PKT_LEN_DEFAULT];

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every register both ways, bad ops, a command at reset delay
		push_beat(OP_READ8, REG_ALT, 16'h0000);
		push_beat(OP_READ8, REG_STATUS, 16'hFFFF);
		push_beat(OP_READ8, REG_SECTNUM, 16'h0000);
		push_beat(OP_READ8, REG_BCLO, 16'h0000);
		push_beat(OP_READ8, REG_BCHI, 16'h0000);
		push_beat(OP_READ8, REG_DATA, 16'h0000);
		push_beat(OP_READ8, REG_FEATURES, 16'h0000);
		push_beat(OP_READ8, REG_SECTCNT, 16'h0000);
		push_beat(OP_WRITE8, REG_ALT, 16'h00FF);
		push_beat(OP_WRITE8, REG_FEATURES, 16'hFF5A);
		push_beat(OP_WRITE8, REG_SECTCNT, 16'h00A5);
		push_beat(OP_WRITE8, REG_BCLO, 16'h00FF);
		push_beat(OP_WRITE8, REG_BCHI, 16'hFFFF);
		push_beat(OP_WRITE8, REG_DATA, 16'h1234);
		push_beat(OP_WRITE8, REG_SECTNUM, 16'h00FF);
		push_beat(OP_READ8, REG_BCLO, 16'h0000);
		push_beat(OP_READ8, REG_BCHI, 16'h0000);
		push_beat(OP_READ16, REG_DATA, 16'h0000);
		push_beat(OP_READ16, REG_ALT, 16'h0000);
		push_beat(OP_WRITE16, REG_STATUS, 16'hFFFF);
		for (int o = OP_TICK + 1; o < 8; o++)
			push_beat(3'(o), 3'(o), 16'hFFFF);
		push_beat(OP_WRITE8, REG_STATUS, {8'h00, CMD_PACKET});
		repeat (2) push_beat(OP_TICK, REG_ALT, 16'h0000);
		push_beat(OP_READ8, REG_STATUS, 16'h0000);

		// random: mostly well-formed command and packet exchanges
		for (int p = 0; p < 8; p++) begin
			settle();
			set_delay(delay_plan[p]);
			while (beats_sent < 27 + (p + 1) * 165) begin
				pick = $urandom_range(0, 99);
				if (pick < 45) begin
					// packet command, twelve bytes, run, then drain the data block
					n = $urandom_range(0, 9);
					code = (n < 4) ? PKT_REQ_MODE : (n < 7) ? PKT_TEST_UNIT : 8'($urandom);
					len = ($urandom_range(0, 19) == 0) ? 255 : $urandom_range(0, 13);
					push_beat(OP_WRITE8, REG_STATUS, {8'($urandom), CMD_PACKET});
					cmd_ticks();
					for (int b = 0; b < PKT_LEN_DEFAULT; b++)
						pkt[b] = 8'($urandom);
					pkt[0] = code;
					pkt[REQ_LEN_BYTE] = len[7:0];
					for (int b = 0; b < PKT_LEN_DEFAULT; b += 2)
						push_beat(OP_WRITE16, REG_DATA, {pkt[b + 1], pkt[b]});
					if ($urandom_range(0, 9) == 0)
						push_beat(OP_WRITE16, REG_DATA, 16'($urandom));
					if ($urandom_range(0, 3) == 0)
						push_beat(OP_READ8, REG_ALT, 16'($urandom));
					cmd_ticks();
					n = (code == PKT_REQ_MODE) ? (len + 1) / 2 + $urandom_range(0, 2)
						: $urandom_range(0, 1);
					repeat (n) push_beat(OP_READ16, REG_DATA, 16'($urandom));
					push_beat(OP_READ8, $urandom_range(0, 1) ? REG_STATUS : REG_ALT,
						16'($urandom));
					push_beat(OP_READ8, 3'($urandom_range(REG_SECTNUM, REG_BCHI)),
						16'($urandom));
				end else if (pick < 60) begin
					// plain ATA command
					n = $urandom_range(0, 9);
					code = (n < 5) ? CMD_SET_FEATURES : (n < 7) ? CMD_PACKET : 8'($urandom);
					push_beat(OP_WRITE8, REG_STATUS, {8'($urandom), code});
					if ($urandom_range(0, 1) == 0)
						push_beat(OP_READ8, REG_STATUS, 16'($urandom));
					cmd_ticks();
					push_beat(OP_READ8, $urandom_range(0, 1) ? REG_STATUS : REG_ALT,
						16'($urandom));
				end else if (pick < 68) begin
					// second command lands on a pending one
					push_beat(OP_WRITE8, REG_STATUS, 16'($urandom));
					repeat ($urandom_range(0, 2)) push_beat(OP_TICK, 3'($urandom),
						16'($urandom));
					push_beat(OP_WRITE8, REG_STATUS, {8'($urandom), CMD_SET_FEATURES});
					cmd_ticks();
					push_beat(OP_READ8, REG_STATUS, 16'($urandom));
				end else begin
					// noise over the whole op and register space
					repeat ($urandom_range(1, 6))
						push_beat(3'($urandom), 3'($urandom), 16'($urandom));
					if (pick == 99)
						settle();
				end
			end
		end

		settle();
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

// File: sim.f
sv/atapk_pkg.sv
sv/atapk_in_stage.sv
sv/atapk_out_stage.sv
sv/atapk_core.sv
sv/ata_packet_drive_registers.sv
bench/atapk_regs_checker.sv
bench/tb_ata_packet_drive_registers.sv
